FILE: rtl/assert_macros.svh
// Assertion macros used by the datapath module of the LIS length tracker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

FILE: rtl/lis_pkg.sv
// Package of types and constants for the LIS length tracker.
`default_nettype none

package lis_pkg;

  localparam int MAX_LEN_DEF    = 1024;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int VALUE_W        = 32;
  localparam int LEN_W          = 11;

  // Input transaction payload.
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } item_t;

  // Result transaction payload.
  typedef struct packed {
    logic [LEN_W-1:0] length;
    logic             final_res;
    logic             overflow;
  } res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;
    logic step;
    logic update;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic more;
    logic out_stall;
  } stat_t;

endpackage

`default_nettype wire

FILE: rtl/lis_ctrl.sv
// Controller state machine of the LIS length tracker.
`default_nettype none

module lis_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_ready,
  input  lis_pkg::stat_t stat,
  output lis_pkg::cmd_t  cmd
);
  import lis_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_UPDATE = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // Decode commands and the next state.
  always_comb begin
    state_next = state;
    cmd        = '0;
    item_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.start  = 1'b1;
          state_next = stat.more ? ST_SEARCH : ST_UPDATE;
        end
      end
      ST_SEARCH: begin
        cmd.step = 1'b1;
        if (!stat.more) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (!stat.out_stall) begin
          cmd.update = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Advance the state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lis_dp.sv
// Datapath of the LIS length tracker: tail store, search bounds, count and result register.
`default_nettype none

`include "assert_macros.svh"

module lis_dp #(
  parameter int MAX_LEN    = lis_pkg::MAX_LEN_DEF,
  parameter int DATA_WIDTH = lis_pkg::DATA_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  lis_pkg::item_t item,
  input  lis_pkg::cmd_t  cmd,
  output lis_pkg::stat_t stat,
  output logic           res_valid,
  input  logic           res_ready,
  output lis_pkg::res_t  res
);
  import lis_pkg::*;

  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam int IDX_W = $clog2(MAX_LEN);
  localparam int EXT_W = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;
  localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_LEN);

  logic [DATA_WIDTH-1:0] tails [MAX_LEN];

  logic [DATA_WIDTH-1:0] key;
  logic                  last;
  logic [CNT_W-1:0]      lo;
  logic [CNT_W-1:0]      hi;
  logic [CNT_W-1:0]      mid;
  logic [CNT_W-1:0]      count;
  logic                  overflowed;
  logic [DATA_WIDTH-1:0] rdata;

  logic [CNT_W-1:0]      lo_next;
  logic [CNT_W-1:0]      hi_next;
  logic [CNT_W-1:0]      mid_next;
  logic [EXT_W-1:0]      value_ext;
  logic [DATA_WIDTH-1:0] key_in;
  logic                  replace;
  logic                  wr_en;
  logic [CNT_W-1:0]      count_upd;
  logic                  ovf_upd;

  // Map the low bits of the value to an order-preserving unsigned key.
  assign value_ext = EXT_W'(item.value);
  assign key_in    = value_ext[DATA_WIDTH-1:0] ^ {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // Open the search interval on start or narrow it from the last probe, then pick the next probe.
  always_comb begin
    lo_next = lo;
    hi_next = hi;
    if (cmd.start) begin
      lo_next = '0;
      hi_next = count;
    end else if (cmd.step) begin
      if (rdata < key) begin
        lo_next = CNT_W'(mid + 1'b1);
      end else begin
        hi_next = mid;
      end
    end
    mid_next = CNT_W'(lo_next + ((hi_next - lo_next) >> 1));
  end

  assign stat.more      = (lo_next < hi_next);
  assign stat.out_stall = res_valid && !res_ready;

  // Decide between replace, append and a dropped append.
  assign replace   = (lo < count);
  assign wr_en     = cmd.update && (replace || (count < FULL));
  assign count_upd = (!replace && (count < FULL)) ? CNT_W'(count + 1'b1) : count;
  assign ovf_upd   = overflowed || (!replace && (count == FULL));

  // Probe and update the tail store.
  always_ff @(posedge clk) begin
    if ((cmd.start || cmd.step) && stat.more) begin
      rdata <= tails[mid_next[IDX_W-1:0]];
    end
    if (wr_en) begin
      tails[lo[IDX_W-1:0]] <= key;
    end
  end

  // Hold the item and the search bounds.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key  <= key_in;
      last <= item.last;
    end
    if ((cmd.start || cmd.step) && stat.more) begin
      mid <= mid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lo <= '0;
      hi <= '0;
    end else begin
      lo <= lo_next;
      hi <= hi_next;
    end
  end

  // Advance the length and overflow flag; clear them after the last item.
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      overflowed <= 1'b0;
    end else if (cmd.update) begin
      count      <= last ? '0 : count_upd;
      overflowed <= last ? 1'b0 : ovf_upd;
    end
  end

  // Load the result register; drop it once the transaction completes.
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      res.length    <= LEN_W'(count_upd);
      res.final_res <= last;
      res.overflow  <= ovf_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.update) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  `ASSERT_ALWAYS(a_bounds_order, lo <= hi, "search bounds crossed")
  `ASSERT_ALWAYS(a_count_range, count <= FULL, "count beyond store depth")
  `ASSERT_IMPLIES(a_ovf_full, overflowed, count == FULL, "overflow flag without full store")
  `ASSERT_IMPLIES(a_res_from_update, $rose(res_valid), $past(cmd.update),
                  "result raised without an update")

endmodule

`default_nettype wire

FILE: rtl/lis_length_tracker.sv
// Top level of the LIS length tracker: controller and datapath.
//
//   channel | direction | payload          | handshake
//   item    | in        | lis_pkg::item_t  | item_valid / item_ready
//   res     | out       | lis_pkg::res_t   | res_valid / res_ready
//
// Each item passes through an accept state that issues the first probe, the probe
// states of the binary search (at most ceil(log2(count + 1)) probes, at most 11 for 1024
// tails) and a state for the tail store write; the store has one memory read port.
// Reset clears the length, the overflow flag and the handshake state; the tail store is
// not cleared, and only entries below the length are ever read.
// A result waiting on res_ready holds the write cycle of the next item.
`default_nettype none

module lis_length_tracker #(
  parameter int MAX_LEN    = lis_pkg::MAX_LEN_DEF,
  parameter int DATA_WIDTH = lis_pkg::DATA_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_ready,
  input  lis_pkg::item_t item,
  output logic           res_valid,
  input  logic           res_ready,
  output lis_pkg::res_t  res
);
  import lis_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  lis_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  lis_dp #(
    .MAX_LEN    (MAX_LEN),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cmd       (cmd),
    .stat      (stat),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// Testbench for the LIS length tracker: random and directed sequences checked against a predictor.
`timescale 1ns / 1ps

module tb_top;
  import lis_pkg::*;

  localparam int DEPTH    = MAX_LEN_DEF;
  localparam int HOLD_LEN = 400;

  localparam logic signed [VALUE_W-1:0] MOST_NEG = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic signed [VALUE_W-1:0] MOST_POS = {1'b0, {(VALUE_W-1){1'b1}}};

  typedef enum int {SHAPE_WIDE, SHAPE_NARROW, SHAPE_RISING, SHAPE_CORNERS} shape_t;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  item_valid = 1'b0;
  logic  item_ready;
  item_t item = '0;
  logic  res_valid;
  logic  res_ready = 1'b0;
  res_t  res;

  // Tail store, length and overflow of the running sequence as predicted
  logic signed [VALUE_W-1:0] tail_min [DEPTH];
  int   run_len = 0;
  logic run_ovf = 1'b0;

  item_t pending_items [$];
  res_t  pending_results [$];
  res_t  want;

  logic item_taken = 1'b0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   hold_seq = 0;
  int   hold_seen = 0;
  int   hold_left = 0;

  int items_queued = 0;
  int items_done = 0;
  int sequences_queued = 0;
  int results_checked = 0;
  int overflow_results = 0;
  int mismatches = 0;
  int phase_base = 0;

  lis_length_tracker dut (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  always #5 clk = ~clk;

  // Advance the predicted patience-sort state by one transaction
  function automatic res_t advance_tracker(item_t it);
    logic signed [VALUE_W-1:0] v;
    int   lo;
    int   hi;
    int   mid;
    res_t r;
    v  = it.value;
    lo = 0;
    hi = run_len;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (tail_min[mid] < v) lo = mid + 1;
      else hi = mid;
    end
    if (lo < run_len) begin
      if (tail_min[lo] != v) tail_min[lo] = v;
    end else if (run_len < DEPTH) begin
      tail_min[run_len] = v;
      run_len++;
    end else begin
      run_ovf = 1'b1;
    end
    r.length    = run_len[LEN_W-1:0];
    r.final_res = it.last;
    r.overflow  = run_ovf;
    if (it.last) begin
      run_len = 0;
      run_ovf = 1'b0;
    end
    return r;
  endfunction

  // Drive the item channel from the pending queue
  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || item_taken) begin
      if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        item       <= pending_items.pop_front();
        item_valid <= 1'b1;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // Drive res_ready: random stalls, or a long hold-off when requested
  always @(negedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_ready <= 1'b0;
    end else begin
      res_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Predict on each item transaction; check each result transaction
  always @(posedge clk) begin
    item_taken <= !rst && item_valid && item_ready;
    if (!rst && item_valid && item_ready) begin
      pending_results.push_back(advance_tracker(item));
      items_done++;
    end
    if (!rst && res_valid && res_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no transaction outstanding: length %0d", res.length);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (want.overflow) overflow_results++;
        if (res.length !== want.length) begin
          $error("length: expected %0d, actual %0d", want.length, res.length);
          mismatches++;
        end
        if (res.final_res !== want.final_res) begin
          $error("final_res: expected %0b, actual %0b", want.final_res, res.final_res);
          mismatches++;
        end
        if (res.overflow !== want.overflow) begin
          $error("overflow: expected %0b, actual %0b", want.overflow, res.overflow);
          mismatches++;
        end
      end
    end
  end

  task automatic add_item(logic signed [VALUE_W-1:0] v, logic is_last);
    item_t it;
    it.value = v;
    it.last  = is_last;
    pending_items.push_back(it);
    items_queued++;
    if (is_last) sequences_queued++;
  endtask

  // Wait until every queued transaction is accepted and answered
  task automatic drain();
    while (items_done < items_queued || pending_results.size() > 0) @(posedge clk);
  endtask

  // Switch the idle settings once the given number of transactions is accepted
  task automatic switch_idle_at(int n_done, int send_pct, int stall_pct);
    while (items_done < n_done) @(posedge clk);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
  endtask

  // Queue one complete sequence of n values with a random shape
  task automatic queue_sequence(int n);
    shape_t shape;
    logic signed [VALUE_W-1:0] v;
    logic signed [VALUE_W-1:0] base;
    shape = shape_t'($urandom_range(3));
    base  = $urandom;
    for (int i = 0; i < n; i++) begin
      case (shape)
        SHAPE_WIDE: v = $urandom;
        SHAPE_NARROW: v = int'($urandom_range(15)) - 8;
        SHAPE_RISING: begin
          base = base + $urandom_range(3);
          v = ($urandom_range(4) == 0) ? $urandom : base;
        end
        default: begin
          case ($urandom_range(4))
            0: v = MOST_NEG;
            1: v = MOST_POS;
            2: v = '0;
            3: v = -1;
            default: v = $urandom;
          endcase
        end
      endcase
      add_item(v, i == n - 1);
    end
  endtask

  task automatic random_phase(int send_pct, int stall_pct, int n_items);
    int target;
    int n;
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    target = items_queued + n_items;
    while (items_queued < target) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 30);
      if (n > target - items_queued) n = target - items_queued;
      queue_sequence(n);
    end
    drain();
  endtask

  // Fill the tail store past its depth, then end the sequence and add a single-item sequence
  task automatic queue_overflow_run();
    longint step_val;
    for (int i = 0; i < DEPTH + 4; i++) begin
      step_val = longint'(MOST_NEG) + longint'(i) * 4000000 + $urandom_range(3999999);
      add_item(step_val[VALUE_W-1:0], 1'b0);
    end
    add_item(MOST_NEG, 1'b0);
    add_item(MOST_POS, 1'b0);
    add_item('0, 1'b1);
    add_item(-1, 1'b1);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: ignore, replace, append, extremes, single-item and falling sequences
    add_item(0, 1'b0);
    add_item(0, 1'b0);
    add_item(MOST_NEG, 1'b0);
    add_item(MOST_POS, 1'b0);
    add_item(5, 1'b0);
    add_item(5, 1'b0);
    add_item(MOST_POS, 1'b0);
    add_item(-1, 1'b0);
    add_item(3, 1'b1);
    add_item(-1, 1'b1);
    add_item(MOST_POS, 1'b0);
    add_item(MOST_POS, 1'b0);
    add_item(MOST_POS, 1'b1);
    add_item(10, 1'b0);
    add_item(9, 1'b0);
    add_item(-5, 1'b0);
    add_item(MOST_NEG, 1'b0);
    add_item(MOST_NEG, 1'b1);
    add_item(32'shAAAA_AAAA, 1'b0);
    add_item(1, 1'b0);
    add_item(2, 1'b0);
    add_item(32'sh5555_5555, 1'b0);
    add_item(4, 1'b1);
    drain();

    // Fill the store past its depth while stepping through the idle settings
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    phase_base = items_done;
    queue_overflow_run();
    switch_idle_at(phase_base + 260, 50, 0);
    switch_idle_at(phase_base + 520, 0, 50);
    switch_idle_at(phase_base + 780, 21, 21);
    drain();

    random_phase(0, 0, 20);
    random_phase(21, 21, 20);

    // Hold off the receiver while the sender keeps offering
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_seq++;
    queue_sequence(10);
    queue_sequence(10);
    drain();

    repeat (40) @(posedge clk);
    $display("Checked %0d results from %0d items in %0d sequences under four idle settings,",
             results_checked, items_done, sequences_queued);
    $display("a long receiver hold-off and a store overflow run (%0d results flagged overflow).",
             overflow_results);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #(5_000_000);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
